@@ hw/rtl/fmc_pkg.sv @@
// ---------------------------------------------------------------------------
// fmc_pkg: shared types and constants of the first-match rule classifier
// Rule table geometry, field codes, stream item layout and the scan state.
// ---------------------------------------------------------------------------
`default_nettype none

package fmc_pkg;

  localparam int RULE_SLOTS = 16;
  localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W      = $clog2(RULE_SLOTS + 1);

  localparam int PORT_W     = 17;
  localparam int ADDR_W     = 32;
  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 8;

  localparam logic       KIND_WRITE    = 1'b0;
  localparam logic       KIND_CLASSIFY = 1'b1;

  localparam logic [1:0] DIR_ANY       = 2'd2;
  localparam logic [1:0] PROTO_ANY     = 2'd0;
  localparam logic [1:0] PROTO_TCP     = 2'd1;
  localparam logic [1:0] ACK_ANY       = 2'd2;
  localparam logic [1:0] ACT_DENY      = 2'd0;
  localparam logic [1:0] ACT_ALLOW     = 2'd1;

  typedef struct packed {
    logic [6:0]  pad;
    logic [2:0]  rule_flags;
    logic [33:0] dst_ports;
    logic [33:0] src_ports;
    logic [31:0] dst_mask;
    logic [31:0] dst_addr;
    logic [31:0] src_mask;
    logic [31:0] src_addr;
    logic [1:0]  ack;
    logic [1:0]  protocol;
    logic [1:0]  direction;
    logic [3:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [3:0]        match_slot;
    logic              matched;
    logic              allowed;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] src_mask;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] dst_mask;
    logic [PORT_W-1:0] src_lo;
    logic [PORT_W-1:0] src_hi;
    logic [PORT_W-1:0] dst_lo;
    logic [PORT_W-1:0] dst_hi;
    logic [1:0]        direction;
    logic [1:0]        protocol;
    logic [1:0]        ack;
    logic [1:0]        action;
  } rule_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] src_pnum;
    logic [PORT_W-1:0] dst_pnum;
    logic [1:0]        direction;
    logic [1:0]        protocol;
    logic [1:0]        ack;
  } pkt_t;

  typedef struct packed {
    logic hit;
    logic allow;
  } match_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/first_match_packet_rule_classifier_core.sv @@
// ---------------------------------------------------------------------------
// first_match_packet_rule_classifier_core: first-match rule table classifier
// Holds a table of rules in a synchronous memory and scans it per packet.
// ---------------------------------------------------------------------------
// The input stream carries one item per transfer. in_tuser selects the kind:
// a write loads one whole rule slot, a classify item asks for a verdict.
// Every item yields exactly one transfer on the output stream.
// A write goes straight to S_OUT to show its result. A classify item
// reads the rule memory one slot per cycle, in index order, and checks each
// rule the cycle after its read; the scan ends at the first hit, or after
// the last slot with no hit, and its result then waits in S_OUT for the
// output register. The next item can be taken in the cycle after the result
// enters the output register.
// While the receiver stalls, the output register holds its result; the
// block still takes and works on one more item, then holds that result
// and takes nothing new until the output register is free.
// Reset clears the valid bit of every slot, so the table starts empty and
// every packet is denied by default; rule contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module first_match_packet_rule_classifier_core
  import fmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // slot, direction, protocol, ack, src_addr, src_mask, dst_addr, dst_mask,
  // src_ports, dst_ports, rule_flags, then zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic                  in_tuser,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // allowed, matched, match_slot, then zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  rule_t                mem [RULE_SLOTS];

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 q_valid_r, q_valid_nxt;
  logic [SLOT_W-1:0]    q_idx_r;
  rule_t                rule_q_r;
  pkt_t                 pkt_r, pkt_nxt;
  out_item_t            res_r, res_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic [RULE_SLOTS-1:0] valid_r;

  in_item_t             item;
  rule_t                wr_rule;
  logic                 in_fire;
  logic                 mem_we;
  logic [SLOT_W+3:0]    slot_ext;
  logic [SLOT_W-1:0]    wr_addr;
  logic [SLOT_W+3:0]    idx_ext;
  logic                 issue;
  logic                 hit_now;
  logic                 last_rule;
  logic                 out_free;
  match_t               m;

  assign item      = in_item_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_ext  = {SLOT_W'(0), item.slot};
  assign wr_addr   = slot_ext[SLOT_W-1:0];
  assign mem_we    = in_fire && (in_tuser == KIND_WRITE) &&
                     (slot_ext < (SLOT_W + 4)'(RULE_SLOTS));
  assign idx_ext   = {4'b0, q_idx_r};

  always_comb begin
    wr_rule.src_addr  = item.src_addr;
    wr_rule.src_mask  = item.src_mask;
    wr_rule.dst_addr  = item.dst_addr;
    wr_rule.dst_mask  = item.dst_mask;
    wr_rule.src_lo    = item.src_ports[33:17];
    wr_rule.src_hi    = item.src_ports[16:0];
    wr_rule.dst_lo    = item.dst_ports[33:17];
    wr_rule.dst_hi    = item.dst_ports[16:0];
    wr_rule.direction = item.direction;
    wr_rule.protocol  = item.protocol;
    wr_rule.ack       = item.ack;
    wr_rule.action    = item.rule_flags[1:0];
  end

  fmc_rule_match u_match (
    .rule       (rule_q_r),
    .rule_valid (valid_r[q_idx_r]),
    .pkt        (pkt_r),
    .result     (m)
  );

  assign hit_now   = q_valid_r && m.hit;
  assign last_rule = q_valid_r && (q_idx_r == SLOT_W'(RULE_SLOTS - 1));
  assign issue     = (state_r == S_SCAN) && (rd_idx_r < CNT_W'(RULE_SLOTS)) &&
                     !hit_now;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    q_valid_nxt    = issue;
    pkt_nxt        = pkt_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_item_nxt   = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          if (in_tuser == KIND_WRITE) begin
            state_nxt = S_OUT;
          end else begin
            pkt_nxt.src_addr  = item.src_addr;
            pkt_nxt.dst_addr  = item.dst_addr;
            pkt_nxt.src_pnum  = item.src_ports[16:0];
            pkt_nxt.dst_pnum  = item.dst_ports[16:0];
            pkt_nxt.direction = item.direction;
            pkt_nxt.protocol  = item.protocol;
            pkt_nxt.ack       = item.ack;
            rd_idx_nxt        = '0;
            state_nxt         = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (hit_now) begin
          res_nxt.allowed    = m.allow;
          res_nxt.matched    = 1'b1;
          res_nxt.match_slot = idx_ext[3:0];
          state_nxt          = S_OUT;
        end else if (last_rule) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_item_nxt   = res_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_rule;
    end
    rule_q_r <= mem[rd_idx_r[SLOT_W-1:0]];
    q_idx_r  <= rd_idx_r[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_idx_r     <= '0;
      q_valid_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      valid_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_idx_r     <= rd_idx_nxt;
      q_valid_r    <= q_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (mem_we) begin
        valid_r[wr_addr] <= item.rule_flags[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    pkt_r      <= pkt_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_item_r.match_slot, out_item_r.matched,
                       out_item_r.allowed};

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid_r |-> (state_r == S_SCAN))
    else $error("rule read data pending outside of a scan");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= CNT_W'(RULE_SLOTS))
    else $error("scan index ran past the table");

  a_allow_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> out_tdata[1])
    else $error("allow given without a deciding rule");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> ((state_r != S_IDLE) || $past(hit_now || last_rule)
      || (state_r == S_SCAN)))
    else $error("scan left without a verdict");

endmodule

`default_nettype wire

@@ hw/rtl/fmc_rule_match.sv @@
// ---------------------------------------------------------------------------
// fmc_rule_match: compares one stored rule against a packet
// Direction, masked addresses, port ranges, protocol, ACK and action checks.
// ---------------------------------------------------------------------------
`default_nettype none

module fmc_rule_match
  import fmc_pkg::*;
(
  input  rule_t  rule,
  input  logic   rule_valid,
  input  pkt_t   pkt,
  output match_t result
);

  logic dir_ok;
  logic src_ok;
  logic dst_ok;
  logic sport_ok;
  logic dport_ok;
  logic proto_ok;
  logic ack_ok;
  logic act_ok;

  always_comb begin
    dir_ok   = (rule.direction == pkt.direction) || (rule.direction == DIR_ANY);
    src_ok   = ((rule.src_addr ^ pkt.src_addr) & rule.src_mask) == '0;
    dst_ok   = ((rule.dst_addr ^ pkt.dst_addr) & rule.dst_mask) == '0;
    sport_ok = (pkt.src_pnum >= rule.src_lo) && (pkt.src_pnum <= rule.src_hi);
    dport_ok = (pkt.dst_pnum >= rule.dst_lo) && (pkt.dst_pnum <= rule.dst_hi);
    proto_ok = (rule.protocol == pkt.protocol) || (rule.protocol == PROTO_ANY);
    ack_ok   = (pkt.protocol != PROTO_TCP) || (rule.ack == pkt.ack) ||
               (rule.ack == ACK_ANY);
    act_ok   = (rule.action == ACT_DENY) || (rule.action == ACT_ALLOW);

    result.hit   = rule_valid && dir_ok && src_ok && dst_ok && sport_ok &&
                   dport_ok && proto_ok && ack_ok && act_ok;
    result.allow = (rule.action == ACT_ALLOW);
  end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for first_match_packet_rule_classifier_core
// Loads rule slots and sends packets over the input stream. A model of the
// rule table predicts each verdict, and every output transfer is checked
// against the oldest pending verdict. Both stream sides idle at random, but not in the run that turns idling off.
// ---------------------------------------------------------------------------

module tb;
  import fmc_pkg::*;

  localparam logic [1:0] DIR_IN      = 2'd0;
  localparam logic [1:0] DIR_OUT     = 2'd1;
  localparam logic [1:0] DIR_ODD     = 2'd3;
  localparam logic [1:0] PROTO_NONE  = 2'd0;
  localparam logic [1:0] PROTO_UDP   = 2'd2;
  localparam logic [1:0] PROTO_OTHER = 2'd3;
  localparam logic [1:0] ACK_CLEAR   = 2'd0;
  localparam logic [1:0] ACK_SET     = 2'd1;
  localparam logic [1:0] ACK_ODD     = 2'd3;
  localparam logic [1:0] ACT_UNKNOWN = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam logic [16:0] PORT_NONE  = 17'd65536;
  localparam logic [33:0] ALL_PORTS  = {17'h00000, 17'h1FFFF};
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic      in_idle_en  = 1'b1;
  logic      out_idle_en = 1'b1;
  int        errors      = 0;
  int        quiet       = 0;
  rule_t     rule_tab[RULE_SLOTS]   = '{default: '0};
  logic      rule_valid[RULE_SLOTS] = '{default: 1'b0};
  out_item_t verdict_q[$];
  out_item_t want_v;
  out_item_t got_v;

  first_match_packet_rule_classifier_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_item_t table_verdict(input logic kind, input in_item_t it);
    out_item_t        res;
    rule_t            r;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
    res   = '0;
    sport = it.src_ports[PORT_W-1:0];
    dport = it.dst_ports[PORT_W-1:0];
    if (kind == KIND_WRITE) begin
      if (it.slot < RULE_SLOTS) begin
        r.src_addr  = it.src_addr;
        r.src_mask  = it.src_mask;
        r.dst_addr  = it.dst_addr;
        r.dst_mask  = it.dst_mask;
        r.src_lo    = it.src_ports[33:17];
        r.src_hi    = it.src_ports[16:0];
        r.dst_lo    = it.dst_ports[33:17];
        r.dst_hi    = it.dst_ports[16:0];
        r.direction = it.direction;
        r.protocol  = it.protocol;
        r.ack       = it.ack;
        r.action    = it.rule_flags[1:0];
        rule_tab[it.slot]   = r;
        rule_valid[it.slot] = it.rule_flags[2];
      end
      return res;
    end
    for (int i = 0; i < RULE_SLOTS; i++) begin
      r = rule_tab[i];
      if (!rule_valid[i]) continue;
      if (!(r.direction == it.direction || r.direction == DIR_ANY)) continue;
      if (((r.src_addr ^ it.src_addr) & r.src_mask) != '0) continue;
      if (((r.dst_addr ^ it.dst_addr) & r.dst_mask) != '0) continue;
      if (sport < r.src_lo || sport > r.src_hi) continue;
      if (dport < r.dst_lo || dport > r.dst_hi) continue;
      if (!(r.protocol == it.protocol || r.protocol == PROTO_ANY)) continue;
      if (it.protocol == PROTO_TCP && !(r.ack == it.ack || r.ack == ACK_ANY)) continue;
      if (r.action != ACT_DENY && r.action != ACT_ALLOW) continue;
      res.allowed    = (r.action == ACT_ALLOW);
      res.matched    = 1'b1;
      res.match_slot = 4'(i);
      return res;
    end
    return res;
  endfunction

  // Output transfers are checked before the input transfer of the same edge
  // is predicted, so the verdict order follows the stream order.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_v = out_tdata;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
      end else begin
        want_v = verdict_q.pop_front();
        if (got_v.allowed !== want_v.allowed) begin
          errors++;
          $display("%0t: allowed expected %b actual %b", $time, want_v.allowed,
                   got_v.allowed);
        end
        if (got_v.matched !== want_v.matched) begin
          errors++;
          $display("%0t: matched expected %b actual %b", $time, want_v.matched,
                   got_v.matched);
        end
        if (got_v.match_slot !== want_v.match_slot) begin
          errors++;
          $display("%0t: match_slot expected %0d actual %0d", $time,
                   want_v.match_slot, got_v.match_slot);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      verdict_q.push_back(table_verdict(in_tuser, in_tdata));
    end
  end

  always @(posedge clk) begin
    out_tready <= !out_idle_en || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic in_item_t make_rule(input logic [3:0] slot, input logic [1:0] dir,
                                         input logic [1:0] proto, input logic [1:0] ack,
                                         input logic [31:0] saddr, input logic [31:0] smask,
                                         input logic [31:0] daddr, input logic [31:0] dmask,
                                         input logic [33:0] sports, input logic [33:0] dports,
                                         input logic [2:0] flags);
    in_item_t it;
    it            = '0;
    it.slot       = slot;
    it.direction  = dir;
    it.protocol   = proto;
    it.ack        = ack;
    it.src_addr   = saddr;
    it.src_mask   = smask;
    it.dst_addr   = daddr;
    it.dst_mask   = dmask;
    it.src_ports  = sports;
    it.dst_ports  = dports;
    it.rule_flags = flags;
    return it;
  endfunction

  // Fields that a packet does not use are filled with noise.
  function automatic in_item_t make_packet(input logic [1:0] dir, input logic [1:0] proto,
                                           input logic [1:0] ack, input logic [31:0] saddr,
                                           input logic [31:0] daddr, input logic [16:0] sport,
                                           input logic [16:0] dport);
    in_item_t it;
    it            = '0;
    it.slot       = 4'($urandom());
    it.direction  = dir;
    it.protocol   = proto;
    it.ack        = ack;
    it.src_addr   = saddr;
    it.src_mask   = $urandom();
    it.dst_addr   = daddr;
    it.dst_mask   = $urandom();
    it.src_ports  = {17'($urandom()), sport};
    it.dst_ports  = {17'($urandom()), dport};
    it.rule_flags = 3'($urandom());
    return it;
  endfunction

  function automatic logic [31:0] random_mask();
    int          len;
    logic [31:0] m;
    m = '0;
    case ($urandom_range(0, 3))
      0: begin
        len = $urandom_range(0, 32);
        if (len != 0) m = ~32'h0 << (32 - len);
      end
      1: begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 1) == 1) m[8*k +: 8] = 8'hFF;
        end
      end
      2: m = $urandom();
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [33:0] random_range();
    logic [16:0] lo;
    logic [16:0] hi;
    lo = 17'($urandom());
    hi = 17'($urandom());
    case ($urandom_range(0, 3))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: hi = lo;
      2: hi = (lo > 17'h1FFFF - 17'd64) ? 17'h1FFFF : lo + 17'($urandom_range(0, 63));
      default: ;
    endcase
    return {lo, hi};
  endfunction

  function automatic logic [1:0] weighted_code(input logic [1:0] a, input logic [1:0] b,
                                               input logic [1:0] c, input logic [1:0] rare);
    int d;
    d = $urandom_range(0, 9);
    return (d < 3) ? a : (d < 6) ? b : (d < 9) ? c : rare;
  endfunction

  function automatic in_item_t random_rule();
    logic [1:0] act;
    logic [2:0] flags;
    act   = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
    flags = {($urandom_range(0, 99) < 85), act};
    return make_rule(4'($urandom()), weighted_code(DIR_IN, DIR_OUT, DIR_ANY, DIR_ODD),
                     2'($urandom()), weighted_code(ACK_CLEAR, ACK_SET, ACK_ANY, ACK_ODD),
                     $urandom(), random_mask(), $urandom(), random_mask(),
                     random_range(), random_range(), flags);
  endfunction

  function automatic logic [16:0] port_within(input logic [16:0] lo, input logic [16:0] hi);
    int span;
    if ($urandom_range(0, 19) == 0) return PORT_NONE;
    if (lo > hi) return 17'($urandom());
    span = int'(hi) - int'(lo) + 1;
    return 17'(int'(lo) + int'($urandom_range(0, span - 1)));
  endfunction

  // Builds a packet aimed at the rule in the given slot, then sometimes flips
  // one bit so that it may just miss.
  function automatic in_item_t packet_for(input int s);
    rule_t    r;
    in_item_t p;
    int       b;
    r = rule_tab[s];
    p = make_packet((r.direction == DIR_ANY) ? 2'($urandom_range(0, 1)) : r.direction,
                    (r.protocol == PROTO_ANY) ? 2'($urandom()) : r.protocol,
                    (r.ack == ACK_ANY) ? 2'($urandom_range(0, 1)) : r.ack,
                    (r.src_addr & r.src_mask) | ($urandom() & ~r.src_mask),
                    (r.dst_addr & r.dst_mask) | ($urandom() & ~r.dst_mask),
                    port_within(r.src_lo, r.src_hi), port_within(r.dst_lo, r.dst_hi));
    if ($urandom_range(0, 3) == 0) begin
      b = $urandom_range(0, 31);
      case ($urandom_range(0, 6))
        0: p.src_addr[b] = ~p.src_addr[b];
        1: p.dst_addr[b] = ~p.dst_addr[b];
        2: p.src_ports[b % 17] = ~p.src_ports[b % 17];
        3: p.dst_ports[b % 17] = ~p.dst_ports[b % 17];
        4: p.direction[b % 2] = ~p.direction[b % 2];
        5: p.protocol[b % 2] = ~p.protocol[b % 2];
        default: p.ack[b % 2] = ~p.ack[b % 2];
      endcase
    end
    return p;
  endfunction

  task automatic send_item(input logic kind, input in_item_t item);
    int gap;
    gap = 0;
    if (in_idle_en && $urandom_range(99) < 35) gap = $urandom_range(1, 20);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= item;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic test_empty_table();
    send_item(KIND_CLASSIFY, make_packet(DIR_IN, PROTO_NONE, ACK_CLEAR, '0, '0, '0, '0));
    send_item(KIND_CLASSIFY, make_packet(DIR_ODD, PROTO_OTHER, ACK_ODD, '1, '1, '1, '1));
  endtask

  task automatic test_rule_semantics();
    send_item(KIND_WRITE, make_rule(4'd0, DIR_ANY, PROTO_ANY, ACK_ANY, '0, '0, '0, '0,
                                    ALL_PORTS, ALL_PORTS, {1'b1, ACT_UNKNOWN}));
    send_item(KIND_WRITE, make_rule(4'd1, DIR_IN, PROTO_TCP, ACK_SET,
                                    32'h0A00_0000, 32'hFF00_0000, '0, '0, ALL_PORTS,
                                    {17'd80, 17'd80}, {1'b1, ACT_DENY}));
    send_item(KIND_WRITE, make_rule(4'd2, DIR_ODD, PROTO_OTHER, ACK_ODD,
                                    32'hC0A8_0100, 32'hFF00_FF00, '0, '0,
                                    {17'd1024, 17'd2047}, ALL_PORTS, {1'b1, ACT_ALLOW}));
    send_item(KIND_WRITE, make_rule(4'd3, DIR_ANY, PROTO_ANY, ACK_ANY, '0, '0, '0, '0,
                                    ALL_PORTS, ALL_PORTS, {1'b0, ACT_ALLOW}));
    send_item(KIND_WRITE, make_rule(4'd4, DIR_OUT, PROTO_UDP, ACK_CLEAR, '0, '0, '1, '1,
                                    ALL_PORTS, ALL_PORTS, {1'b1, ACT_RESERVED}));
    send_item(KIND_WRITE, make_rule(4'd14, DIR_ODD, PROTO_OTHER, ACK_ODD, '1, '1, '1, '1,
                                    '1, '1, '1));
    send_item(KIND_WRITE, make_rule(4'd15, DIR_ANY, PROTO_ANY, ACK_ANY, '0, '0, '0, '0,
                                    ALL_PORTS, ALL_PORTS, {1'b1, ACT_ALLOW}));
    send_item(KIND_CLASSIFY, make_packet(DIR_IN, PROTO_TCP, ACK_SET, 32'h0A01_0203,
                                         32'h0808_0808, 17'd40000, 17'd80));
    send_item(KIND_CLASSIFY, make_packet(DIR_IN, PROTO_TCP, ACK_CLEAR, 32'h0A01_0203,
                                         32'h0808_0808, 17'd40000, 17'd80));
    send_item(KIND_CLASSIFY, make_packet(DIR_IN, PROTO_UDP, ACK_SET, 32'h0A01_0203,
                                         32'h0808_0808, 17'd40000, 17'd80));
    send_item(KIND_CLASSIFY, make_packet(DIR_ODD, PROTO_OTHER, ACK_ODD, 32'hC0FF_01AA,
                                         '0, 17'd1024, PORT_NONE));
    send_item(KIND_CLASSIFY, make_packet(DIR_ODD, PROTO_TCP, ACK_ODD, 32'hC0FF_01AA,
                                         '0, 17'd2047, PORT_NONE));
    send_item(KIND_CLASSIFY, make_packet(DIR_ODD, PROTO_OTHER, ACK_ODD, 32'hC0FF_01AA,
                                         '0, 17'd2048, PORT_NONE));
    send_item(KIND_CLASSIFY, make_packet(DIR_ODD, PROTO_OTHER, ACK_ODD, '1, '1, '1, '1));
    send_item(KIND_WRITE, make_rule(4'd15, DIR_ANY, PROTO_ANY, ACK_ANY, '0, '0, '0, '0,
                                    ALL_PORTS, ALL_PORTS, {1'b0, ACT_DENY}));
    send_item(KIND_CLASSIFY, make_packet(DIR_OUT, PROTO_UDP, ACK_CLEAR, '0, '1, '0, '0));
  endtask

  task automatic test_rule_traffic(input int n_items, input logic idle);
    int       sent;
    int       s;
    int       tries;
    in_item_t it;
    in_idle_en  = idle;
    out_idle_en <= idle;
    sent = 0;
    for (int k = 0; k < RULE_SLOTS; k++) begin
      it      = random_rule();
      it.slot = 4'(k);
      send_item(KIND_WRITE, it);
      sent++;
    end
    while (sent < n_items) begin
      repeat ($urandom_range(0, 4)) begin
        send_item(KIND_WRITE, random_rule());
        sent++;
      end
      repeat ($urandom_range(4, 16)) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(KIND_CLASSIFY, make_packet(2'($urandom()), 2'($urandom()),
                                               2'($urandom()), $urandom(), $urandom(),
                                               17'($urandom()), 17'($urandom())));
        end else begin
          s     = $urandom_range(0, RULE_SLOTS - 1);
          tries = 0;
          while (!rule_valid[s] && tries < 4) begin
            s = $urandom_range(0, RULE_SLOTS - 1);
            tries++;
          end
          send_item(KIND_CLASSIFY, packet_for(s));
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_rule_semantics();
    test_rule_traffic(200, 1'b0);
    test_rule_traffic(600, 1'b1);
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/fmc_pkg.sv
hw/rtl/fmc_rule_match.sv
hw/rtl/first_match_packet_rule_classifier_core.sv
bench/tb.sv
